>>> design/cde_pkg.sv
package cde_pkg;

  localparam int DEPTH       = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int CAP_W       = 7;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;

  localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(5);
  localparam logic             GROW_RESET = 1'b1;

  // Configuration register indexes.
  localparam logic REG_CAPACITY_LIMIT = 1'b0;
  localparam logic REG_GROW_ENABLE    = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic add_front;
    logic add_back;
    logic take_front;
    logic take_back;
  } ctl_t;

endpackage

>>> design/cde_cell.sv
module cde_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  cde_pkg::ctl_t                   ctl,
  input  logic [cde_pkg::VALUE_WIDTH-1:0] new_value,
  input  logic [cde_pkg::VALUE_WIDTH-1:0] prev_val,
  input  logic                            prev_occ,
  input  logic [cde_pkg::VALUE_WIDTH-1:0] next_val,
  input  logic                            next_occ,
  output logic [cde_pkg::VALUE_WIDTH-1:0] val,
  output logic                            occ,
  output logic [cde_pkg::VALUE_WIDTH-1:0] back_tap
);

  logic [cde_pkg::VALUE_WIDTH-1:0] val_next;
  logic                            occ_next;

  // Occupancy is a thermometer code: a push shifts it toward the back,
  // a pop shifts it toward the front.
  always_comb begin
    occ_next = occ;
    if (ctl.add_front || ctl.add_back) begin
      occ_next = prev_occ;
    end else if (ctl.take_front || ctl.take_back) begin
      occ_next = next_occ;
    end
  end

  always_comb begin
    val_next = val;
    if (ctl.add_front) begin
      val_next = prev_val;
    end else if (ctl.add_back && prev_occ && !occ) begin
      val_next = new_value;
    end else if (ctl.take_front) begin
      val_next = next_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

  // The last occupied cell offers its value for the back of the queue.
  assign back_tap = (occ && !next_occ) ? val : '0;

endmodule

>>> design/circular_deque_engine.sv
// Double-ended queue engine.
//
// Input channel (in_valid / in_ready): one word carries an opcode and an
// item_value. Opcodes push at the front or back, pop from the front or back,
// or peek at either end. Every accepted word yields exactly one result word
// on the output channel (out_valid / out_ready) holding read_value, status
// and count_after.
//
// The entries live in a row of identical cells. The front is always cell 0
// and occupancy is a thermometer code across the row, so a push or pop at
// the front shifts the whole row by one cell, while a push or pop at the
// back only moves the occupancy boundary. The back value is collected from
// the single cell that sits at that boundary.
//
// out_valid rises in the cycle after acceptance. Throughput is one word
// per cycle: the result register is reloaded in the same cycle that its word
// is taken. When the receiver stalls, the result is held and in_ready drops
// until the result is taken. Reset empties the queue, sets capacity_limit to
// 5 and grow_enable to 1; no clearing pass is needed. With grow_enable set
// the full 64 entries are usable, otherwise capacity_limit (capped at 64).
module circular_deque_engine (
  input  logic                            clk,
  input  logic                            rst,
  // Input channel.
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cde_pkg::OP_W-1:0]        opcode,
  input  logic [31:0]                     item_value,
  // Output channel.
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [31:0]                     read_value,
  output logic [cde_pkg::STATUS_W-1:0]    status,
  output logic [cde_pkg::CNT_W-1:0]       count_after,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [cde_pkg::CAP_W-1:0]       cfg_data
);

  localparam int D  = cde_pkg::DEPTH;
  localparam int VW = cde_pkg::VALUE_WIDTH;
  localparam int CW = cde_pkg::CNT_W;

  // Configuration registers.
  logic [cde_pkg::CAP_W-1:0] capacity_limit;
  logic                      grow_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= cde_pkg::CAP_RESET;
      grow_enable    <= cde_pkg::GROW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cde_pkg::REG_CAPACITY_LIMIT: capacity_limit <= cfg_data;
        cde_pkg::REG_GROW_ENABLE:    grow_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The usable limit is the whole row when growth is enabled, otherwise the
  // configured capacity saturated to the row length.
  logic [CW-1:0] usable_limit;

  always_comb begin
    if (grow_enable) begin
      usable_limit = CW'(D);
    end else if (CW'(capacity_limit) > CW'(D)) begin
      usable_limit = CW'(D);
    end else begin
      usable_limit = CW'(capacity_limit);
    end
  end

  // Entry count, kept alongside the occupancy code for the result field.
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic accept;
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Row of cells.
  logic [VW-1:0] cell_val [D];
  logic          cell_occ [D];
  logic [VW-1:0] cell_tap [D];
  logic [VW-1:0] new_value;
  cde_pkg::ctl_t ctl;

  assign new_value = item_value[VW-1:0];

  for (genvar i = 0; i < D; i++) begin : g_cell
    logic [VW-1:0] prev_val;
    logic          prev_occ;
    logic [VW-1:0] next_val;
    logic          next_occ;

    if (i == 0) begin : g_head
      assign prev_val = new_value;
      assign prev_occ = 1'b1;
    end else begin : g_body
      assign prev_val = cell_val[i-1];
      assign prev_occ = cell_occ[i-1];
    end

    if (i == D - 1) begin : g_tail
      assign next_val = '0;
      assign next_occ = 1'b0;
    end else begin : g_inner
      assign next_val = cell_val[i+1];
      assign next_occ = cell_occ[i+1];
    end

    cde_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .new_value (new_value),
      .prev_val  (prev_val),
      .prev_occ  (prev_occ),
      .next_val  (next_val),
      .next_occ  (next_occ),
      .val       (cell_val[i]),
      .occ       (cell_occ[i]),
      .back_tap  (cell_tap[i])
    );
  end

  // At most one cell offers a nonzero tap, so an OR gathers the back value.
  logic [VW-1:0] back_value;

  always_comb begin
    back_value = '0;
    for (int i = 0; i < D; i++) begin
      back_value = back_value | cell_tap[i];
    end
  end

  // Decode of the accepted word.
  logic             full;
  logic             empty;
  logic [VW-1:0]    rd_value;
  cde_pkg::status_t rd_status;

  assign full  = (count >= usable_limit);
  assign empty = (count == '0);

  always_comb begin
    ctl        = '0;
    rd_value   = '0;
    rd_status  = cde_pkg::ST_OK;
    count_next = count;
    unique case (cde_pkg::opcode_t'(opcode)) inside
      cde_pkg::OP_PUSH_FRONT, cde_pkg::OP_PUSH_BACK: begin
        if (full) begin
          rd_status = cde_pkg::ST_FULL;
        end else begin
          ctl.add_front = (cde_pkg::opcode_t'(opcode) == cde_pkg::OP_PUSH_FRONT);
          ctl.add_back  = (cde_pkg::opcode_t'(opcode) == cde_pkg::OP_PUSH_BACK);
          count_next    = count + CW'(1);
        end
      end
      cde_pkg::OP_POP_FRONT, cde_pkg::OP_PEEK_FRONT: begin
        if (empty) begin
          rd_status = cde_pkg::ST_EMPTY;
        end else begin
          rd_value       = cell_val[0];
          ctl.take_front = (cde_pkg::opcode_t'(opcode) == cde_pkg::OP_POP_FRONT);
          if (ctl.take_front) begin
            count_next = count - CW'(1);
          end
        end
      end
      cde_pkg::OP_POP_BACK, cde_pkg::OP_PEEK_BACK: begin
        if (empty) begin
          rd_status = cde_pkg::ST_EMPTY;
        end else begin
          rd_value      = back_value;
          ctl.take_back = (cde_pkg::opcode_t'(opcode) == cde_pkg::OP_POP_BACK);
          if (ctl.take_back) begin
            count_next = count - CW'(1);
          end
        end
      end
      default: ;  // Unused opcodes leave the queue alone and report OK.
    endcase
    if (!accept) begin
      ctl        = '0;
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value  <= 32'(rd_value);
      status      <= rd_status;
      count_after <= count_next;
    end
  end

endmodule

>>> design/cde_checker.sv
module cde_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [31:0]                  read_value,
  input logic [cde_pkg::STATUS_W-1:0] status,
  input logic [cde_pkg::CNT_W-1:0]    count_after
);

  // A refused operation never returns data.
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == cde_pkg::ST_FULL || status == cde_pkg::ST_EMPTY)
    |-> read_value == '0)
    else $error("refused word carries data");

  // The reported count never exceeds the row length.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> count_after <= cde_pkg::CNT_W'(cde_pkg::DEPTH))
    else $error("count_after out of range");

  // An empty refusal can only come with an empty queue.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == cde_pkg::ST_EMPTY |-> count_after == '0)
    else $error("empty status with nonzero count");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_value)
      && $stable(status) && $stable(count_after))
    else $error("stalled result changed");

  // Every accepted word shows its result in the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

endmodule

bind circular_deque_engine cde_checker u_cde_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .read_value  (read_value),
  .status      (status),
  .count_after (count_after)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // An initial block builds the stimulus as a queue of command words and
  // writes the two configuration registers between phases, at times when no
  // word is in flight. A driver feeds the input channel at the falling edge,
  // and the monitor checks results at the rising edge against a behavioral
  // copy of the queue.

  // Opcodes 6 and 7 have no operation; the block must ignore them.
  localparam logic [cde_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [cde_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [cde_pkg::OP_W-1:0] op;
    logic [31:0]              value;
  } cmd_word_t;

  typedef struct packed {
    logic [31:0]               value;
    cde_pkg::status_t          st;
    logic [cde_pkg::CNT_W-1:0] count;
  } result_word_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [cde_pkg::OP_W-1:0]     opcode = '0;
  logic [31:0]                  item_value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [31:0]                  read_value;
  logic [cde_pkg::STATUS_W-1:0] status;
  logic [cde_pkg::CNT_W-1:0]    count_after;
  logic                         cfg_we = 1'b0;
  logic                         cfg_index = 1'b0;
  logic [cde_pkg::CAP_W-1:0]    cfg_data = '0;

  circular_deque_engine dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .item_value  (item_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_value  (read_value),
    .status      (status),
    .count_after (count_after),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #4 clk = ~clk;

  // Stimulus words not yet offered, and results predicted but not yet seen.
  cmd_word_t    word_backlog[$];
  result_word_t due_results[$];
  int           errors = 0;

  // Handshakes seen at the last rising edge. The driver reads these at the
  // next falling edge, so that it never depends on event order.
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;

  // Idle control: percent chance to start an idle burst of random length.
  int idle_pct = 0;
  int in_gap = 0;
  int out_gap = 0;

  // Behavioral copy of the queue. The front pointer moves down on a push at
  // the front, and the back pointer moves up on a push at the back. Both
  // pointers are 6 bits wide, so they wrap around the 64 slots by themselves.
  logic [31:0]               slot_copy [cde_pkg::DEPTH];
  logic [5:0]                head_pos = '0;
  logic [5:0]                tail_pos = '1;
  logic [cde_pkg::CNT_W-1:0] fill = '0;
  logic [cde_pkg::CAP_W-1:0] cap_cfg = cde_pkg::CAP_RESET;
  logic                      grow_cfg = cde_pkg::GROW_RESET;

  function automatic result_word_t deque_apply(logic [cde_pkg::OP_W-1:0] op,
                                               logic [31:0] v);
    result_word_t r;
    int unsigned  lim;
    r.value = '0;
    r.st    = cde_pkg::ST_OK;
    // With growth on, the whole store is usable. Otherwise the limit is the
    // capacity register, capped at the physical depth.
    if (grow_cfg)
      lim = cde_pkg::DEPTH;
    else
      lim = (cap_cfg > cde_pkg::DEPTH) ? cde_pkg::DEPTH : cap_cfg;
    case (op) inside
      cde_pkg::OP_PUSH_FRONT, cde_pkg::OP_PUSH_BACK: begin
        // A push is refused whenever the count is at or above the limit.
        // This holds also when the limit was lowered below the stored count.
        if (fill >= lim) begin
          r.st = cde_pkg::ST_FULL;
        end else if (op == cde_pkg::OP_PUSH_FRONT) begin
          head_pos = head_pos - 1'b1;
          slot_copy[head_pos] = v;
          fill = fill + 1'b1;
        end else begin
          tail_pos = tail_pos + 1'b1;
          slot_copy[tail_pos] = v;
          fill = fill + 1'b1;
        end
      end
      cde_pkg::OP_POP_FRONT, cde_pkg::OP_POP_BACK,
      cde_pkg::OP_PEEK_FRONT, cde_pkg::OP_PEEK_BACK: begin
        if (fill == 0) begin
          r.st = cde_pkg::ST_EMPTY;
        end else begin
          case (op)
            cde_pkg::OP_POP_FRONT: begin
              r.value  = slot_copy[head_pos];
              head_pos = head_pos + 1'b1;
              fill     = fill - 1'b1;
            end
            cde_pkg::OP_POP_BACK: begin
              r.value  = slot_copy[tail_pos];
              tail_pos = tail_pos - 1'b1;
              fill     = fill - 1'b1;
            end
            cde_pkg::OP_PEEK_FRONT: r.value = slot_copy[head_pos];
            default:                r.value = slot_copy[tail_pos];
          endcase
        end
      end
      default: ;  // Unused opcodes change nothing and report OK.
    endcase
    r.count = fill;
    return r;
  endfunction

  task automatic report(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Monitor. Results are checked before the word accepted in the same edge
  // is predicted. A result always belongs to an earlier word.
  always @(posedge clk) begin : monitor
    result_word_t want;
    if (rst) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= in_valid && in_ready;
      out_fire <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report("result word with no prediction waiting");
        end else begin
          want = due_results[0];
          due_results.delete(0);
          if (read_value !== want.value)
            report($sformatf("read_value got %h, expected %h", read_value, want.value));
          if (status !== want.st)
            report($sformatf("status got %0d, expected %0d", status, want.st));
          if (count_after !== want.count)
            report($sformatf("count_after got %0d, expected %0d", count_after, want.count));
        end
      end
      if (in_valid && in_ready)
        due_results = {due_results, deque_apply(opcode, item_value)};
    end
  end

  // Driver. A new word is offered only after the current one was taken.
  // Each signal gets at most one nonblocking write per falling edge.
  always @(negedge clk) begin : driver
    cmd_word_t w;
    if (!rst) begin
      if (!in_valid || in_fire) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (word_backlog.size() > 0) begin
          w = word_backlog[0];
          word_backlog.delete(0);
          opcode     <= w.op;
          item_value <= w.value;
          in_valid   <= 1'b1;
          if ($urandom_range(0, 99) < idle_pct)
            in_gap = $urandom_range(1, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < idle_pct)
          out_gap = $urandom_range(1, 5);
      end
    end
  end

  task automatic queue_word(logic [cde_pkg::OP_W-1:0] op, logic [31:0] v);
    cmd_word_t w;
    w.op    = op;
    w.value = v;
    word_backlog = {word_backlog, w};
  endtask

  // Returns at a falling edge once every word was sent and every result
  // was checked.
  task automatic wait_idle();
    while (word_backlog.size() != 0 || in_valid || due_results.size() != 0)
      @(negedge clk);
  endtask

  // Register write, one cycle wide. The copy in the predictor changes at
  // the same time. No word is in flight while this runs.
  task automatic write_reg(logic idx, logic [cde_pkg::CAP_W-1:0] data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_we    <= 1'b1;
    if (idx == cde_pkg::REG_CAPACITY_LIMIT)
      cap_cfg = data;
    else
      grow_cfg = data[0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random traffic in runs. Each run leans either toward pushes, which fill
  // the queue up to its limit, or toward pops and peeks, which drain it. A
  // few unused opcodes are mixed in as noise; they do not count toward the
  // quota.
  task automatic random_run(int quota);
    int                       done;
    int                       span;
    int                       push_bias;
    logic [cde_pkg::OP_W-1:0] op;
    logic [31:0]              v;
    done = 0;
    while (done < quota) begin
      span      = $urandom_range(8, 90);
      push_bias = ($urandom_range(0, 1) != 0) ? 85 : 20;
      for (int k = 0; k < span && done < quota; k++) begin
        if ($urandom_range(0, 99) < 3)
          op = ($urandom_range(0, 1) != 0) ? OP_UNUSED_HI : OP_UNUSED_LO;
        else if ($urandom_range(0, 99) < push_bias)
          op = ($urandom_range(0, 1) != 0) ? cde_pkg::OP_PUSH_BACK : cde_pkg::OP_PUSH_FRONT;
        else
          op = cde_pkg::OP_W'($urandom_range(cde_pkg::OP_POP_FRONT, cde_pkg::OP_PEEK_BACK));
        case ($urandom_range(0, 9))
          0:       v = '0;
          1:       v = '1;
          default: v = $urandom();
        endcase
        queue_word(op, v);
        if (op <= cde_pkg::OP_PEEK_BACK)
          done++;
      end
    end
  endtask

  // Settings for the random phases. A capacity of 127 checks that the limit
  // saturates at the depth. Later phases begin with whatever the earlier
  // ones left stored, so a lowered limit often falls below the count.
  int phase_cap  [12] = '{127, 64, 1, 0, 40, 2, 64, 127, 7, 64, 3, 64};
  int phase_grow [12] = '{1, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0, 1};
  int phase_idle [12] = '{20, 35, 10, 0, 30, 20, 15, 40, 25, 10, 0, 0};

  initial begin : stimulus
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    idle_pct = 20;

    // Reset settings, growth on. Pops and peeks on an empty queue and the
    // two unused opcodes come first. Then the extreme values go in at both
    // ends, are read at both ends, and are drained until the queue is
    // empty again.
    queue_word(cde_pkg::OP_POP_FRONT, 32'h1234_5678);
    queue_word(cde_pkg::OP_POP_BACK, '1);
    queue_word(cde_pkg::OP_PEEK_FRONT, '0);
    queue_word(cde_pkg::OP_PEEK_BACK, 32'hDEAD_BEEF);
    queue_word(OP_UNUSED_LO, 32'hAAAA_AAAA);
    queue_word(OP_UNUSED_HI, 32'h5555_5555);
    queue_word(cde_pkg::OP_PUSH_FRONT, '0);
    queue_word(cde_pkg::OP_PUSH_BACK, '1);
    queue_word(cde_pkg::OP_PEEK_FRONT, '0);
    queue_word(cde_pkg::OP_PEEK_BACK, '0);
    queue_word(cde_pkg::OP_PUSH_FRONT, 32'h8000_0001);
    queue_word(cde_pkg::OP_POP_BACK, '0);
    queue_word(cde_pkg::OP_POP_FRONT, '0);
    queue_word(cde_pkg::OP_POP_FRONT, '0);
    queue_word(cde_pkg::OP_POP_BACK, '0);
    wait_idle();

    // Growth off and a capacity of zero: every push is refused as full.
    write_reg(cde_pkg::REG_GROW_ENABLE, cde_pkg::CAP_W'(0));
    write_reg(cde_pkg::REG_CAPACITY_LIMIT, cde_pkg::CAP_W'(0));
    queue_word(cde_pkg::OP_PUSH_FRONT, 32'h0000_0011);
    queue_word(cde_pkg::OP_PUSH_BACK, 32'h0000_0022);
    wait_idle();

    // A capacity of two: the third push is refused.
    write_reg(cde_pkg::REG_CAPACITY_LIMIT, cde_pkg::CAP_W'(2));
    queue_word(cde_pkg::OP_PUSH_BACK, 32'hA0A0_A0A0);
    queue_word(cde_pkg::OP_PUSH_FRONT, 32'h0B0B_0B0B);
    queue_word(cde_pkg::OP_PUSH_BACK, 32'hC0C0_C0C0);
    wait_idle();

    // The limit drops below the stored count. The entries stay, and pushes
    // are refused until the count is below the limit again.
    write_reg(cde_pkg::REG_CAPACITY_LIMIT, cde_pkg::CAP_W'(1));
    queue_word(cde_pkg::OP_PUSH_FRONT, 32'h1111_1111);
    queue_word(cde_pkg::OP_POP_BACK, '0);
    queue_word(cde_pkg::OP_PUSH_BACK, 32'h2222_2222);
    queue_word(cde_pkg::OP_POP_FRONT, '0);
    queue_word(cde_pkg::OP_PUSH_BACK, 32'h5A5A_5A5A);
    queue_word(cde_pkg::OP_POP_FRONT, '0);
    wait_idle();

    // The random phases follow. The last two run without idle cycles.
    for (int p = 0; p < 12; p++) begin
      write_reg(cde_pkg::REG_GROW_ENABLE, cde_pkg::CAP_W'(phase_grow[p]));
      write_reg(cde_pkg::REG_CAPACITY_LIMIT, cde_pkg::CAP_W'(phase_cap[p]));
      idle_pct = phase_idle[p];
      random_run(125);
      wait_idle();
    end

    repeat (4) @(posedge clk);
    if (errors == 0)
      $display("circular_deque_engine regression: pass");
    else
      $display("circular_deque_engine regression: fail");
    $finish;
  end

  // Watchdog, far above the slowest correct run.
  initial begin : watchdog
    #5000000;
    $display("circular_deque_engine regression: fail");
    $finish;
  end

endmodule
